### src/ppsch_pkg.sv
// shared types and constants of the preemptive priority scheduler
`default_nettype none

package ppsch_pkg;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;
    localparam logic [4:0]  COUNT_MAX = 5'd31;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [3:0]  slot;
        logic [7:0]  task_id;
        logic [7:0]  task_priority;
        logic [15:0] arrival_time;
        logic [15:0] burst_length;
    } t_req;

    typedef struct packed {
        logic        ran;
        logic [7:0]  ran_id;
        logic        finished;
        logic [31:0] finish_time;
        logic [31:0] wait_time;
        logic [31:0] turnaround;
        logic [31:0] time_now;
        logic [4:0]  done_count;
        logic [31:0] wait_sum;
        logic [31:0] turnaround_sum;
        logic        all_done;
    } t_res;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] remaining;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic scan_start;
        logic scan;
        logic apply;
        logic exec_run;
        logic exec_turn;
        logic exec_wait;
        logic exec_sums;
        logic publish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

### src/ppsch_if.sv
// request and result channel interfaces
`default_nettype none

interface ppsch_req_if;
    import ppsch_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ppsch_res_if;
    import ppsch_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### src/ppsch_ram.sv
// generic single write port ram with registered read
`default_nettype none

module ppsch_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### src/ppsch_dp.sv
// scheduler datapath: entry memory, ready flags, scan, timing arithmetic, result register
`default_nettype none

module ppsch_dp #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ppsch_pkg::t_cmd i_cmd,
    input  wire ppsch_pkg::t_req i_req,
    output ppsch_pkg::t_sts      o_sts,
    output ppsch_pkg::t_res      o_res,
    output logic                 o_res_valid,
    input  wire logic            i_res_ready
);

    import ppsch_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_TASKS - 1);

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? TIME_MAX : s[31:0];
    endfunction

    // request held for the whole operation
    t_req r_req;

    // control state
    logic [MAX_TASKS-1:0] r_active;
    logic [31:0]          r_time;
    logic [4:0]           r_done;
    logic [31:0]          r_wsum;
    logic [31:0]          r_tsum;
    logic                 r_issuing;
    logic                 r_cmp_vld;
    logic                 r_found;
    logic                 r_fin;
    logic                 r_out_vld;

    // payload registers
    logic [IW-1:0] r_rd_idx;
    logic [IW-1:0] r_cmp_idx;
    logic [IW-1:0] r_best_idx;
    t_entry        r_best;
    logic [31:0]   r_turn;
    logic [31:0]   r_wait;
    t_res          r_out;

    // memory ports
    logic          we;
    logic [IW-1:0] waddr;
    t_entry        wdata;
    t_entry        rdata;
    logic          slot_ok;
    logic          cand;

    assign slot_ok = (32'(r_req.slot) < 32'(MAX_TASKS));

    always_comb begin
        we    = 1'b0;
        waddr = r_best_idx;
        wdata = r_best;
        wdata.remaining = r_best.remaining - 16'd1;
        if (i_cmd.apply && r_req.req_type == REQ_LOAD && slot_ok) begin
            we    = 1'b1;
            waddr = IW'(r_req.slot);
            wdata = '{id: r_req.task_id, prio: r_req.task_priority,
                      arrival: r_req.arrival_time, burst: r_req.burst_length,
                      remaining: r_req.burst_length};
        end else if (i_cmd.exec_run && r_found) begin
            we = 1'b1;
        end
    end

    ppsch_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (rdata)
    );

    // entry under comparison: has work, has arrived, beats the current best
    assign cand = r_cmp_vld && r_active[r_cmp_idx] &&
                  ({16'd0, rdata.arrival} <= r_time) &&
                  (!r_found || rdata.prio < r_best.prio);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_time    <= '0;
            r_done    <= '0;
            r_wsum    <= '0;
            r_tsum    <= '0;
            r_issuing <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_found   <= 1'b0;
            r_fin     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.scan_start) begin
                r_issuing <= 1'b1;
                r_cmp_vld <= 1'b0;
                r_found   <= 1'b0;
            end
            if (i_cmd.scan) begin
                if (r_issuing && r_rd_idx == LAST_IDX) begin
                    r_issuing <= 1'b0;
                end
                r_cmp_vld <= r_issuing;
                if (cand) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.apply) begin
                r_found <= 1'b0;
                r_fin   <= 1'b0;
                case (r_req.req_type)
                    REQ_CLEAR: begin
                        r_active <= '0;
                        r_time   <= '0;
                        r_done   <= '0;
                        r_wsum   <= '0;
                        r_tsum   <= '0;
                    end
                    REQ_LOAD: begin
                        if (slot_ok) begin
                            r_active[IW'(r_req.slot)] <= (r_req.burst_length != 16'd0);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.exec_run) begin
                if (r_time != TIME_MAX) begin
                    r_time <= r_time + 32'd1;
                end
                r_fin <= r_found && (r_best.remaining == 16'd1);
                if (r_found && r_best.remaining == 16'd1) begin
                    r_active[r_best_idx] <= 1'b0;
                end
            end
            if (i_cmd.exec_sums && r_fin) begin
                r_wsum <= sat_add32(r_wsum, r_wait);
                r_tsum <= sat_add32(r_tsum, r_turn);
                if (r_done != COUNT_MAX) begin
                    r_done <= r_done + 5'd1;
                end
            end
            if (i_cmd.publish) begin
                r_out_vld <= 1'b1;
            end else if (i_res_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
        end
        if (i_cmd.scan) begin
            if (r_issuing) begin
                r_rd_idx <= r_rd_idx + IW'(1);
            end
            r_cmp_idx <= r_rd_idx;
            if (cand) begin
                r_best_idx <= r_cmp_idx;
                r_best     <= rdata;
            end
        end
        if (i_cmd.exec_turn) begin
            r_turn <= r_time - {16'd0, r_best.arrival};
        end
        if (i_cmd.exec_wait) begin
            r_wait <= (r_turn >= {16'd0, r_best.burst}) ?
                      r_turn - {16'd0, r_best.burst} : 32'd0;
        end
        if (i_cmd.publish) begin
            r_out.ran            <= r_found;
            r_out.ran_id         <= r_found ? r_best.id : 8'd0;
            r_out.finished       <= r_fin;
            r_out.finish_time    <= r_fin ? r_time : 32'd0;
            r_out.wait_time      <= r_fin ? r_wait : 32'd0;
            r_out.turnaround     <= r_fin ? r_turn : 32'd0;
            r_out.time_now       <= r_time;
            r_out.done_count     <= r_done;
            r_out.wait_sum       <= r_wsum;
            r_out.turnaround_sum <= r_tsum;
            r_out.all_done       <= ~|r_active;
        end
    end

    assign o_sts.scan_done = r_cmp_vld && (r_cmp_idx == LAST_IDX);
    assign o_sts.out_free  = !r_out_vld || i_res_ready;
    assign o_res           = r_out;
    assign o_res_valid     = r_out_vld;

endmodule

`default_nettype wire

### src/ppsch_ctrl.sv
// scheduler controller state machine
`default_nettype none

module ppsch_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [1:0]      i_req_type,
    output logic                 o_ready,
    output ppsch_pkg::t_cmd      o_cmd,
    input  wire ppsch_pkg::t_sts i_sts
);

    import ppsch_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_APPLY = 8'b0000_0010,
        ST_SCAN  = 8'b0000_0100,
        ST_RUN   = 8'b0000_1000,
        ST_TURN  = 8'b0001_0000,
        ST_WAIT  = 8'b0010_0000,
        ST_SUMS  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_req_type == REQ_TICK) begin
                        o_cmd.scan_start = 1'b1;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_APPLY;
                    end
                end
            end
            ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state = ST_OUT;
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.exec_run = 1'b1;
                n_state = ST_TURN;
            end
            ST_TURN: begin
                o_cmd.exec_turn = 1'b1;
                n_state = ST_WAIT;
            end
            ST_WAIT: begin
                o_cmd.exec_wait = 1'b1;
                n_state = ST_SUMS;
            end
            ST_SUMS: begin
                o_cmd.exec_sums = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.publish = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

### src/preemptive_priority_scheduler.sv
// a tick request is captured, then the entry memory is scanned and the run, turnaround, wait and
//   sums steps follow; clear and load apply the request; either result is then registered once
//   the output register is free; one request at a time; the scan reads one entry slot per cycle
// the result register lets the next request in while a result waits to be taken
// reset (synchronous, active low) empties the table, zeroes time, count and sums;
//   entry memory contents are not cleared, an entry counts only once loaded
`default_nettype none

module preemptive_priority_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ppsch_req_if.sink   i_req,
    ppsch_res_if.source o_res
);

    import ppsch_pkg::*;

    // command and status between the controller and the datapath
    t_cmd cmd;
    t_sts sts;
    logic ready;

    // controller: accepts a request, then sequences apply or scan and execute,
    // and holds the result until the output register is free
    ppsch_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.data.req_type),
        .o_ready    (ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // datapath: entry memory swept one slot a cycle to pick the most urgent
    // ready entry (ties to the lowest slot), then registered steps for time,
    // turnaround, wait and the sums, in that order
    ppsch_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req.data),
        .o_sts       (sts),
        .o_res       (o_res.data),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready)
    );

    // a request is taken only while the controller is idle
    assign i_req.ready = ready;

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking testbench for the preemptive priority scheduler
`default_nettype none

module tb;
    import ppsch_pkg::*;

    localparam int TABLE_SLOTS = 16;
    // request code with no meaning, the block only reports status
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    // allow a margin for the drain
    localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 16;
    localparam int TARGET_REQUESTS = 550;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_PRINTED = 40;

    // behavioural model of the scheduler plus the queue of results it predicts
    class sched_scoreboard;
        bit          slot_valid [TABLE_SLOTS];
        logic [7:0]  slot_id [TABLE_SLOTS];
        logic [7:0]  slot_prio [TABLE_SLOTS];
        logic [15:0] slot_arrival [TABLE_SLOTS];
        logic [15:0] slot_burst [TABLE_SLOTS];
        logic [15:0] slot_left [TABLE_SLOTS];
        logic [31:0] clock_now;
        logic [4:0]  done_total;
        logic [31:0] wait_total;
        logic [31:0] turn_total;

        t_res pending_results[$];
        int   errors;
        int   n_requests;
        int   n_ticks;
        int   n_finished;
        int   peak_done;

        function new();
            clear_table();
            errors = 0;
            n_requests = 0;
            n_ticks = 0;
            n_finished = 0;
            peak_done = 0;
        endfunction

        function void clear_table();
            for (int i = 0; i < TABLE_SLOTS; i++) begin
                slot_valid[i] = 0;
                slot_left[i] = '0;
            end
            clock_now = '0;
            done_total = '0;
            wait_total = '0;
            turn_total = '0;
        endfunction

        function logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
            logic [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32] ? TIME_MAX : s[31:0];
        endfunction

        // one scheduler step: apply the request to the model, return its result
        function t_res schedule_step(t_req r);
            t_res        res;
            int          best;
            logic [31:0] turn;
            logic [31:0] burst;
            logic [31:0] wt;
            res = '0;
            best = -1;
            case (r.req_type)
                REQ_CLEAR: begin
                    clear_table();
                end
                REQ_LOAD: begin
                    slot_valid[r.slot] = 1;
                    slot_id[r.slot] = r.task_id;
                    slot_prio[r.slot] = r.task_priority;
                    slot_arrival[r.slot] = r.arrival_time;
                    slot_burst[r.slot] = r.burst_length;
                    slot_left[r.slot] = r.burst_length;
                end
                REQ_TICK: begin
                    // strict less-than keeps the lowest slot on a tie
                    for (int i = 0; i < TABLE_SLOTS; i++) begin
                        if (slot_valid[i] && slot_left[i] != 16'd0 &&
                            {16'd0, slot_arrival[i]} <= clock_now) begin
                            if (best < 0 || slot_prio[i] < slot_prio[best])
                                best = i;
                        end
                    end
                    if (clock_now != TIME_MAX)
                        clock_now = clock_now + 32'd1;
                    if (best >= 0) begin
                        res.ran = 1'b1;
                        res.ran_id = slot_id[best];
                        slot_left[best] = slot_left[best] - 16'd1;
                        if (slot_left[best] == 16'd0) begin
                            turn = clock_now - {16'd0, slot_arrival[best]};
                            burst = {16'd0, slot_burst[best]};
                            wt = (turn >= burst) ? turn - burst : '0;
                            res.finished = 1'b1;
                            res.finish_time = clock_now;
                            res.turnaround = turn;
                            res.wait_time = wt;
                            wait_total = add_sat(wait_total, wt);
                            turn_total = add_sat(turn_total, turn);
                            if (done_total != COUNT_MAX)
                                done_total = done_total + 5'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
            res.time_now = clock_now;
            res.done_count = done_total;
            res.wait_sum = wait_total;
            res.turnaround_sum = turn_total;
            res.all_done = 1'b1;
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (slot_valid[i] && slot_left[i] != 16'd0)
                    res.all_done = 1'b0;
            return res;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_request(t_req r);
            n_requests++;
            if (r.req_type == REQ_TICK)
                n_ticks++;
            pending_results.push_back(schedule_step(r));
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want, int idx);
            if (got !== want)
                report($sformatf("result %0d %s got %h want %h", idx, name, got, want));
        endtask

        task check_result(t_res got);
            t_res want;
            int   idx;
            if (pending_results.size() == 0) begin
                report("result with no request waiting for it");
            end else begin
                want = pending_results.pop_front();
                idx = n_requests - pending_results.size() - 1;
                check_field("ran", 32'(got.ran), 32'(want.ran), idx);
                check_field("ran_id", 32'(got.ran_id), 32'(want.ran_id), idx);
                check_field("finished", 32'(got.finished), 32'(want.finished), idx);
                check_field("finish_time", got.finish_time, want.finish_time, idx);
                check_field("wait_time", got.wait_time, want.wait_time, idx);
                check_field("turnaround", got.turnaround, want.turnaround, idx);
                check_field("time_now", got.time_now, want.time_now, idx);
                check_field("done_count", 32'(got.done_count), 32'(want.done_count), idx);
                check_field("wait_sum", got.wait_sum, want.wait_sum, idx);
                check_field("turnaround_sum", got.turnaround_sum, want.turnaround_sum,
                            idx);
                check_field("all_done", 32'(got.all_done), 32'(want.all_done), idx);
                if (want.finished)
                    n_finished++;
                if (int'(want.done_count) > peak_done)
                    peak_done = int'(want.done_count);
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ppsch_req_if req_if ();
    ppsch_res_if res_if ();

    preemptive_priority_scheduler #(
        .MAX_TASKS (TABLE_SLOTS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    sched_scoreboard sb;

    // set by the stimulus, the first two also read by the result side
    bit no_idle;
    bit hold_results;
    int sent;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit idle_draw();
        return !no_idle && ($urandom_range(0, 99) < 35);
    endfunction

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        bit held;
        held = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_results && !held) begin
                // the sender keeps offering, so the block fills and stalls its input
                held = 1;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                res_if.ready <= i_rst_n && !idle_draw();
            end
        end
    end

    // results are sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.data);
    end

    function automatic t_req make_req(logic [1:0] kind, logic [3:0] s, logic [7:0] id,
                                      logic [7:0] pr, logic [15:0] arr, logic [15:0] bl);
        t_req r;
        r.req_type = kind;
        r.slot = s;
        r.task_id = id;
        r.task_priority = pr;
        r.arrival_time = arr;
        r.burst_length = bl;
        return r;
    endfunction

    // non-load requests carry random junk in the unused fields
    function automatic t_req junk_req(logic [1:0] kind);
        return make_req(kind, 4'($urandom), 8'($urandom), 8'($urandom),
                        16'($urandom), 16'($urandom));
    endfunction

    // a load with content biased towards ties, near arrivals and short bursts
    function automatic t_req random_load();
        logic [31:0] base;
        logic [15:0] arr;
        logic [15:0] bl;
        logic [7:0]  pr;
        base = sb.clock_now + $urandom_range(0, 6);
        if ($urandom_range(0, 15) == 0 || base > 32'h0000_FFFF)
            arr = 16'($urandom);
        else
            arr = base[15:0];
        if ($urandom_range(0, 31) == 0)
            bl = 16'($urandom);
        else
            bl = 16'($urandom_range(0, 5));
        if ($urandom_range(0, 3) == 0)
            pr = 8'($urandom);
        else
            pr = 8'($urandom_range(0, 7));
        return make_req(REQ_LOAD, 4'($urandom), 8'($urandom), pr, arr, bl);
    endfunction

    // starts and ends at a falling edge; valid is only lowered for a gap
    task automatic send_request(t_req r);
        while (idle_draw()) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= r;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(r);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_request(junk_req(REQ_TICK));
    endtask

    initial begin
        int n_loads;
        int n_steps;
        int pick;
        sb = new();
        sent = 0;
        no_idle = 0;
        hold_results = 0;
        i_rst_n = 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: idle tick on an empty table, then an unknown request
        send_ticks(1);
        send_request(junk_req(REQ_UNKNOWN));
        // extreme fields, a late high-priority arrival, a zero burst, a never-ready entry
        send_request(make_req(REQ_LOAD, 4'd0, 8'hFF, 8'hFF, 16'h0000, 16'd2));
        send_request(make_req(REQ_LOAD, 4'd15, 8'h00, 8'h00, 16'd3, 16'd1));
        send_request(make_req(REQ_LOAD, 4'd7, 8'h5A, 8'hFF, 16'h0000, 16'h0000));
        send_request(make_req(REQ_LOAD, 4'd3, 8'h33, 8'h80, 16'hFFFF, 16'hFFFF));
        // ends with an idle tick once only the never-ready and zero-burst entries are left
        send_ticks(5);
        // three-way tie on priority, the reloaded slot 3 is the lowest
        send_request(make_req(REQ_LOAD, 4'd5, 8'h55, 8'h10, 16'h0000, 16'd1));
        send_request(make_req(REQ_LOAD, 4'd9, 8'h99, 8'h10, 16'h0000, 16'd1));
        send_request(make_req(REQ_LOAD, 4'd3, 8'h3C, 8'h10, 16'h0000, 16'd2));
        send_ticks(4);
        // clear, then preemption of a running entry by a more urgent one
        send_request(junk_req(REQ_CLEAR));
        send_ticks(1);
        send_request(make_req(REQ_LOAD, 4'd1, 8'h11, 8'h20, 16'h0000, 16'd3));
        send_ticks(1);
        send_request(make_req(REQ_LOAD, 4'd2, 8'h22, 8'h01, 16'h0000, 16'd1));
        send_ticks(3);

        // random: scenarios of loads followed by ticks, with noise mixed in
        for (int sc = 0; sent < TARGET_REQUESTS; sc++) begin
            // long hold-off on the result side early on
            if (sc == 3)
                hold_results = 1;
            // a stretch with no gaps on either side
            no_idle = (sc >= 10 && sc < 14);
            // scenarios 6..19 draw no deliberate clear, so the completion count can saturate
            if ((sc < 6 || sc >= 20) && $urandom_range(0, 4) == 0)
                send_request(junk_req(REQ_CLEAR));
            n_loads = ($urandom_range(0, 7) == 0) ? TABLE_SLOTS : $urandom_range(1, 6);
            repeat (n_loads) send_request(random_load());
            n_steps = n_loads * 3 + $urandom_range(0, 10);
            if (n_steps > 40)
                n_steps = 40;
            repeat (n_steps) begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                    send_request(random_load());
                else if (pick < 12)
                    send_request(junk_req(REQ_UNKNOWN));
                else if (pick < 14)
                    send_request(junk_req(2'($urandom_range(0, 3))));
                else
                    send_ticks(1);
            end
        end
        req_if.valid <= 1'b0;
        no_idle = 0;

        // wait for every result, then a little longer to catch strays
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_results.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_results.size()));

        $display("covered %0d requests, %0d ticks, %0d task completions",
                 sb.n_requests, sb.n_ticks, sb.n_finished);
        $display("highest completion count %0d, %0d mismatches", sb.peak_done, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
